/* design/pfdc_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfdc_pkg: shared types and helpers for the Playfair digraph cipher
// Letter codes, function codes, square geometry and store port bundles.
// ---------------------------------------------------------------------------
package pfdc_pkg;

   localparam int LETTER_W = 5;
   localparam int CELL_W   = 5;
   localparam int ROW_W    = 3;
   localparam int SQ_DIM   = 5;
   localparam int SQ_CELLS = SQ_DIM * SQ_DIM;
   localparam int LETTERS  = 26;

   localparam logic [LETTER_W-1:0] CODE_I    = LETTER_W'(8);
   localparam logic [LETTER_W-1:0] CODE_J    = LETTER_W'(9);
   localparam logic [LETTER_W-1:0] CODE_Z    = LETTER_W'(25);
   localparam logic [ROW_W-1:0]    LAST_STEP = ROW_W'(SQ_DIM - 1);

   typedef enum logic [1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_ADD   = 2'd1,
      FUNC_ENC   = 2'd2,
      FUNC_DEC   = 2'd3
   } func_type;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_IGNORED = 1'b1;

   // one write places a letter in a cell and records the cell for the letter
   typedef struct packed {
      logic                en;
      logic [CELL_W-1:0]   cell_idx;
      logic [LETTER_W-1:0] letter;
   } store_wr_type;

   typedef struct packed {
      logic [LETTER_W-1:0] pos_letter_a;
      logic [LETTER_W-1:0] pos_letter_b;
      logic [CELL_W-1:0]   cell_a;
      logic [CELL_W-1:0]   cell_b;
   } store_rd_type;

   typedef struct packed {
      logic [CELL_W-1:0]   pos_a;
      logic [CELL_W-1:0]   pos_b;
      logic [LETTER_W-1:0] letter_a;
      logic [LETTER_W-1:0] letter_b;
   } store_data_type;

   // saturate to z, fold j into i
   function automatic logic [LETTER_W-1:0] fold_letter(logic [LETTER_W-1:0] v);
      logic [LETTER_W-1:0] c;
      c = (v > CODE_Z) ? CODE_Z : v;
      return (c == CODE_J) ? CODE_I : c;
   endfunction

   function automatic logic [ROW_W-1:0] cell_row(logic [CELL_W-1:0] idx);
      logic [ROW_W-1:0] r;
      if (idx >= CELL_W'(4 * SQ_DIM))      r = ROW_W'(4);
      else if (idx >= CELL_W'(3 * SQ_DIM)) r = ROW_W'(3);
      else if (idx >= CELL_W'(2 * SQ_DIM)) r = ROW_W'(2);
      else if (idx >= CELL_W'(SQ_DIM))     r = ROW_W'(1);
      else                                 r = ROW_W'(0);
      return r;
   endfunction

   function automatic logic [CELL_W-1:0] row_base(logic [ROW_W-1:0] row);
      return CELL_W'({row, 2'b00}) + CELL_W'(row);
   endfunction

   function automatic logic [ROW_W-1:0] cell_col(logic [CELL_W-1:0] idx);
      logic [CELL_W-1:0] d;
      d = idx - row_base(cell_row(idx));
      return d[ROW_W-1:0];
   endfunction

   function automatic logic [CELL_W-1:0] cell_index(logic [ROW_W-1:0] row,
                                                    logic [ROW_W-1:0] col);
      return row_base(row) + CELL_W'(col);
   endfunction

   // one step along a row or column with wrap: forward on encrypt
   function automatic logic [ROW_W-1:0] wrap_step(logic [ROW_W-1:0] x, logic fwd);
      logic [ROW_W-1:0] r;
      if (fwd) r = (x == LAST_STEP) ? '0 : x + ROW_W'(1);
      else     r = (x == '0) ? LAST_STEP : x - ROW_W'(1);
      return r;
   endfunction

endpackage

/* design/pfdc_store.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pfdc_store: key square storage
// Cell memory (letter per cell) and position memory (cell per letter),
// one shared write port, two registered read ports on each.
// ---------------------------------------------------------------------------
module pfdc_store
   import pfdc_pkg::*;
(
   input  logic           clock,
   input  store_wr_type   wr,
   input  store_rd_type   rd,
   output store_data_type data
);

   logic [LETTER_W-1:0] cell_mem [SQ_CELLS];
   logic [CELL_W-1:0]   pos_mem  [LETTERS];
   store_data_type      data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         cell_mem[wr.cell_idx] <= wr.letter;
         pos_mem[wr.letter]    <= wr.cell_idx;
      end
   end

   always_ff @(posedge clock) begin
      data_ff.pos_a    <= pos_mem[rd.pos_letter_a];
      data_ff.pos_b    <= pos_mem[rd.pos_letter_b];
      data_ff.letter_a <= cell_mem[rd.cell_a];
      data_ff.letter_b <= cell_mem[rd.cell_b];
   end

   assign data = data_ff;

endmodule

/* design/playfair_digraph_cipher.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// playfair_digraph_cipher: Playfair 5x5 key square cipher
// Builds a key square letter by letter and encrypts or decrypts letter pairs.
// ---------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one word per command: req_func selects clear key,
//   add key letter, encrypt pair or decrypt pair; req_letter_a/req_letter_b
//   carry letter codes a=0 .. z=25 (j folds into i, codes above z read as z).
//   The rsp_ channel returns exactly one word per command: rsp_out_a and
//   rsp_out_b hold the cipher pair (zero for key commands), rsp_status flags a
//   key letter that was dropped as out of range, duplicate or square full.
//   Clear and add-key words are answered from the output register once they
//   are accepted. A cipher word on a sealed square passes through position
//   read, cell read, output load and result register.
//   The first cipher word after a key change first seals the square: the
//   sequencer walks all 26 letter codes, one per cycle, filling free cells in
//   order, before that word goes on to the position read.
//   req_ready is high only while the sequencer is idle and the output
//   register is empty or draining; key words can then flow one per cycle.
//   A stalled rsp_ready holds the result word and blocks further commands.
//   Reset empties the key square and the output register, like a clear key.
// ---------------------------------------------------------------------------
module playfair_digraph_cipher
   import pfdc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_func,
   input  logic [LETTER_W-1:0] req_letter_a,
   input  logic [LETTER_W-1:0] req_letter_b,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [LETTER_W-1:0] rsp_out_a,
   output logic [LETTER_W-1:0] rsp_out_b,
   output logic                rsp_status
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SEAL = 5'b00010,
      ST_POS  = 5'b00100,
      ST_MAP  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [LETTERS-1:0]  used_ff, used_in;
   logic [CELL_W-1:0]   fill_ff, fill_in;       // next free cell
   logic                sealed_ff, sealed_in;
   logic [LETTER_W-1:0] scan_ff, scan_in;       // letter under test while sealing
   logic [LETTER_W-1:0] a_ff, a_in, b_ff, b_in;
   logic                fwd_ff, fwd_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LETTER_W-1:0] out_a_ff, out_a_in, out_b_ff, out_b_in;
   logic                status_ff, status_in;

   store_wr_type        wr;
   store_rd_type        rd;
   store_data_type      data;

   func_type            func;
   logic                rsp_free;
   logic                accept;
   logic [LETTER_W-1:0] key_letter;
   logic [ROW_W-1:0]    row_a, col_a, row_b, col_b;
   logic [CELL_W-1:0]   cell_a, cell_b;

   pfdc_store u_store (
      .clock (clock),
      .wr    (wr),
      .rd    (rd),
      .data  (data)
   );

   assign func       = func_type'(req_func);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && rsp_free;
   assign accept     = req_valid && req_ready;
   assign key_letter = fold_letter(req_letter_a);

   // map the pair positions to result cells
   always_comb begin
      row_a = cell_row(data.pos_a);
      col_a = cell_col(data.pos_a);
      row_b = cell_row(data.pos_b);
      col_b = cell_col(data.pos_b);
      priority if (row_a == row_b) begin
         cell_a = cell_index(row_a, wrap_step(col_a, fwd_ff));
         cell_b = cell_index(row_b, wrap_step(col_b, fwd_ff));
      end else if (col_a == col_b) begin
         cell_a = cell_index(wrap_step(row_a, fwd_ff), col_a);
         cell_b = cell_index(wrap_step(row_b, fwd_ff), col_b);
      end else begin
         cell_a = cell_index(row_a, col_b);
         cell_b = cell_index(row_b, col_a);
      end
   end

   // position memory follows the held pair; cell memory follows the mapping
   always_comb begin
      rd.pos_letter_a = a_ff;
      rd.pos_letter_b = b_ff;
      rd.cell_a       = cell_a;
      rd.cell_b       = cell_b;
   end

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      fill_in      = fill_ff;
      sealed_in    = sealed_ff;
      scan_in      = scan_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      fwd_in       = fwd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      out_a_in     = out_a_ff;
      out_b_in     = out_b_ff;
      status_in    = status_ff;
      wr.en        = 1'b0;
      wr.cell_idx  = fill_ff;
      wr.letter    = key_letter;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               a_in   = fold_letter(req_letter_a);
               b_in   = fold_letter(req_letter_b);
               fwd_in = (func == FUNC_ENC);
               unique case (func)
                  FUNC_CLEAR: begin
                     used_in      = '0;
                     fill_in      = '0;
                     sealed_in    = 1'b0;
                     rsp_valid_in = 1'b1;
                     out_a_in     = '0;
                     out_b_in     = '0;
                     status_in    = STATUS_OK;
                  end
                  FUNC_ADD: begin
                     rsp_valid_in = 1'b1;
                     out_a_in     = '0;
                     out_b_in     = '0;
                     // drop out-of-range, duplicate or late key letters, or any on a full square
                     if (req_letter_a > CODE_Z || sealed_ff || used_ff[key_letter] ||
                         fill_ff >= CELL_W'(SQ_CELLS)) begin
                        status_in = STATUS_IGNORED;
                     end else begin
                        status_in           = STATUS_OK;
                        wr.en               = 1'b1;
                        used_in[key_letter] = 1'b1;
                        fill_in             = fill_ff + CELL_W'(1);
                     end
                  end
                  FUNC_ENC, FUNC_DEC: begin
                     scan_in  = '0;
                     state_in = sealed_ff ? ST_POS : ST_SEAL;
                  end
                  default: ;
               endcase
            end
         end
         ST_SEAL: begin
            wr.letter = scan_ff;
            if (scan_ff != CODE_J && !used_ff[scan_ff]) begin
               wr.en            = 1'b1;
               used_in[scan_ff] = 1'b1;
               fill_in          = fill_ff + CELL_W'(1);
            end
            scan_in = scan_ff + LETTER_W'(1);
            if (scan_ff == LETTER_W'(LETTERS - 1)) begin
               sealed_in = 1'b1;
               state_in  = ST_POS;
            end
         end
         ST_POS: begin
            state_in = ST_MAP;
         end
         ST_MAP: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold the looked-up pair until the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               out_a_in     = data.letter_a;
               out_b_in     = data.letter_b;
               status_in    = STATUS_OK;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         fill_ff      <= '0;
         sealed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         fill_ff      <= fill_in;
         sealed_ff    <= sealed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      fwd_ff    <= fwd_in;
      out_a_ff  <= out_a_in;
      out_b_ff  <= out_b_in;
      status_ff <= status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_a  = out_a_ff;
   assign rsp_out_b  = out_b_ff;
   assign rsp_status = status_ff;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the Playfair digraph cipher
// Drives key and cipher words with random gaps, predicts each response word
// from a local copy of the key square, and compares every field in order.
// ---------------------------------------------------------------------------
module tb;
   import pfdc_pkg::*;

   typedef struct packed {
      logic [LETTER_W-1:0] out_a;
      logic [LETTER_W-1:0] out_b;
      logic                status;
   } cipher_word_type;

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                req_valid    = 1'b0;
   logic                req_ready;
   logic [1:0]          req_func     = FUNC_CLEAR;
   logic [LETTER_W-1:0] req_letter_a = '0;
   logic [LETTER_W-1:0] req_letter_b = '0;
   logic                rsp_valid;
   logic                rsp_ready    = 1'b0;
   logic [LETTER_W-1:0] rsp_out_a;
   logic [LETTER_W-1:0] rsp_out_b;
   logic                rsp_status;

   // sender and receiver idling controls, set per phase by the test tasks
   bit req_idle = 1'b1;
   bit rsp_idle = 1'b1;
   int hold_off = 0;      // one-shot long stall, consumed by the receiver

   int error_count = 0;
   int words_sent  = 0;

   // local key square: letters per cell, cell per letter, placement flags
   logic [LETTER_W-1:0] key_cells[SQ_CELLS];
   logic [CELL_W-1:0]   cell_of_letter[LETTERS];
   bit                  letter_placed[LETTERS];
   int                  key_len;
   bit                  sealed;

   cipher_word_type expected_words[$];
   cipher_word_type next_word;

   playfair_digraph_cipher i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_letter_a (req_letter_a),
      .req_letter_b (req_letter_b),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_a    (rsp_out_a),
      .rsp_out_b    (rsp_out_b),
      .rsp_status   (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Key square predictor
   // ------------------------------------------------------------------------

   // clamp codes past z to z, and read j as i
   function automatic logic [LETTER_W-1:0] canon_letter(logic [LETTER_W-1:0] code);
      logic [LETTER_W-1:0] r;
      r = code;
      if (code > CODE_Z) r = CODE_Z;
      else if (code == CODE_J) r = CODE_I;
      return r;
   endfunction

   function automatic void wipe_square();
      for (int i = 0; i < SQ_CELLS; i++) key_cells[i] = '0;
      for (int i = 0; i < LETTERS; i++) begin
         cell_of_letter[i] = '0;
         letter_placed[i]  = 1'b0;
      end
      key_len = 0;
      sealed  = 1'b0;
   endfunction

   function automatic void place_code(logic [LETTER_W-1:0] letter, int slot);
      key_cells[slot]        = letter;
      cell_of_letter[letter] = CELL_W'(slot);
      letter_placed[letter]  = 1'b1;
   endfunction

   // complete the square with the unused letters in alphabetical order
   function automatic void fill_square();
      int slot;
      slot = key_len;
      for (int c = 0; c < LETTERS; c++) begin
         if (slot < SQ_CELLS && c != int'(CODE_J) && !letter_placed[c]) begin
            place_code(LETTER_W'(c), slot);
            slot++;
         end
      end
      sealed = 1'b1;
   endfunction

   // apply one command word to the local square and return its response
   function automatic cipher_word_type predict_word(func_type func,
                                                    logic [LETTER_W-1:0] la,
                                                    logic [LETTER_W-1:0] lb);
      cipher_word_type     w;
      logic [LETTER_W-1:0] k, a, b;
      int                  ra, ca, rb, cb, step, na, nb;
      w = '0;
      case (func)
         FUNC_CLEAR: begin
            wipe_square();
         end
         FUNC_ADD: begin
            k = canon_letter(la);
            if (la > CODE_Z || sealed || letter_placed[k] || key_len >= SQ_CELLS) begin
               w.status = STATUS_IGNORED;
            end else begin
               place_code(k, key_len);
               key_len++;
            end
         end
         default: begin
            if (!sealed) fill_square();
            a    = canon_letter(la);
            b    = canon_letter(lb);
            ra   = int'(cell_of_letter[a]) / SQ_DIM;
            ca   = int'(cell_of_letter[a]) % SQ_DIM;
            rb   = int'(cell_of_letter[b]) / SQ_DIM;
            cb   = int'(cell_of_letter[b]) % SQ_DIM;
            step = (func == FUNC_ENC) ? 1 : SQ_DIM - 1;
            if (ra == rb) begin
               na = ra * SQ_DIM + (ca + step) % SQ_DIM;
               nb = rb * SQ_DIM + (cb + step) % SQ_DIM;
            end else if (ca == cb) begin
               na = ((ra + step) % SQ_DIM) * SQ_DIM + ca;
               nb = ((rb + step) % SQ_DIM) * SQ_DIM + cb;
            end else begin
               na = ra * SQ_DIM + cb;
               nb = rb * SQ_DIM + ca;
            end
            w.out_a = key_cells[na];
            w.out_b = key_cells[nb];
         end
      endcase
      return w;
   endfunction

   // mostly in-range letters, now and then a code past z
   function automatic logic [LETTER_W-1:0] rand_letter();
      logic [LETTER_W-1:0] r;
      if ($urandom_range(0, 11) == 0) r = LETTER_W'($urandom_range(26, 31));
      else r = LETTER_W'($urandom_range(0, 25));
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // offer one word after a random gap, hold it until accepted, then predict
   task automatic send_word(func_type func, logic [LETTER_W-1:0] la,
                            logic [LETTER_W-1:0] lb);
      int gap;
      gap = req_idle ? $urandom_range(0, 15) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= func;
      req_letter_a <= la;
      req_letter_b <= lb;
      do @(posedge clock); while (!req_ready);
      expected_words.push_back(predict_word(func, la, lb));
      words_sent++;
   endtask

   // drop valid and hold until every outstanding response has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stalls, plus the one-shot long hold-off
   // ------------------------------------------------------------------------
   initial begin : rsp_sink
      int stall;
      @(negedge clock);
      forever begin
         stall    = rsp_idle ? $urandom_range(0, 15) : 0;
         stall   += hold_off;
         hold_off = 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // compare each accepted response word against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            error_count++;
            $display("%0t: unexpected response word, out_a %0d out_b %0d status %0d",
                     $time, rsp_out_a, rsp_out_b, rsp_status);
         end else begin
            next_word = expected_words.pop_front();
            if (rsp_out_a !== next_word.out_a) begin
               error_count++;
               $display("%0t: out_a mismatch, expected %0d, actual %0d",
                        $time, next_word.out_a, rsp_out_a);
            end
            if (rsp_out_b !== next_word.out_b) begin
               error_count++;
               $display("%0t: out_b mismatch, expected %0d, actual %0d",
                        $time, next_word.out_b, rsp_out_b);
            end
            if (rsp_status !== next_word.status) begin
               error_count++;
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, next_word.status, rsp_status);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // corner cases on the default square, then on a short keyword square
   task automatic test_directed();
      // default alphabet square: row, column and rectangle pairs both ways
      send_word(FUNC_ENC, 5'd0, 5'd1);
      send_word(FUNC_ENC, 5'd0, 5'd5);
      send_word(FUNC_ENC, 5'd0, 5'd6);
      send_word(FUNC_DEC, 5'd0, 5'd1);
      send_word(FUNC_DEC, 5'd0, 5'd5);
      send_word(FUNC_DEC, 5'd6, 5'd0);
      // j read as i, equal letters in a pair, codes past z, extremes
      send_word(FUNC_ENC, 5'd9, 5'd8);
      send_word(FUNC_ENC, 5'd31, 5'd26);
      send_word(FUNC_DEC, 5'd25, 5'd0);
      // key letter after sealing is dropped
      send_word(FUNC_ADD, 5'd3, 5'd31);
      send_word(FUNC_CLEAR, 5'd31, 5'd31);
      // short keyword, with a duplicate, j folding into i, and out-of-range
      send_word(FUNC_ADD, 5'd15, 5'd0);
      send_word(FUNC_ADD, 5'd11, 5'd0);
      send_word(FUNC_ADD, 5'd0, 5'd0);
      send_word(FUNC_ADD, 5'd24, 5'd0);
      send_word(FUNC_ADD, 5'd0, 5'd0);
      send_word(FUNC_ADD, 5'd9, 5'd0);
      send_word(FUNC_ADD, 5'd8, 5'd0);
      send_word(FUNC_ADD, 5'd31, 5'd0);
      send_word(FUNC_ADD, 5'd26, 5'd0);
      send_word(FUNC_ENC, 5'd7, 5'd8);
      send_word(FUNC_DEC, 5'd25, 5'd25);
      send_word(FUNC_CLEAR, 5'd0, 5'd0);
      send_word(FUNC_ENC, 5'd0, 5'd25);
   endtask

   // stall the response side long enough to back up the request side, then
   // pause the sender until every response is back
   task automatic test_backpressure();
      wait_drained();
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      hold_off = 250;
      send_word(FUNC_CLEAR, 5'd0, 5'd0);
      repeat (6) send_word(FUNC_ADD, rand_letter(), 5'd0);
      repeat (18) send_word($urandom_range(0, 1) ? FUNC_ENC : FUNC_DEC,
                            rand_letter(), rand_letter());
      wait_drained();
      req_idle = 1'b1;
      rsp_idle = 1'b1;
   endtask

   // keyword sessions with random content, mixed with raw noise words
   task automatic test_random();
      int                  start, pick, j;
      logic [LETTER_W-1:0] a, b, tmp;
      logic [LETTER_W-1:0] order[LETTERS];
      start = words_sent;
      while (words_sent - start < 1200) begin
         pick     = $urandom_range(0, 11);
         // most sessions idle on both sides, some run back to back
         req_idle = ($urandom_range(0, 4) != 0);
         rsp_idle = ($urandom_range(0, 4) != 0);
         if (pick == 0) begin
            repeat ($urandom_range(1, 8))
               send_word(func_type'($urandom_range(0, 3)),
                         LETTER_W'($urandom_range(0, 31)),
                         LETTER_W'($urandom_range(0, 31)));
         end else begin
            if ($urandom_range(0, 5) != 0)
               send_word(FUNC_CLEAR, LETTER_W'($urandom_range(0, 31)),
                         LETTER_W'($urandom_range(0, 31)));
            if (pick == 1) begin
               // every letter in shuffled order: fills the square by key alone
               for (int i = 0; i < LETTERS; i++) order[i] = LETTER_W'(i);
               for (int i = LETTERS - 1; i > 0; i--) begin
                  j        = $urandom_range(0, i);
                  tmp      = order[i];
                  order[i] = order[j];
                  order[j] = tmp;
               end
               for (int i = 0; i < LETTERS; i++)
                  send_word(FUNC_ADD, order[i], LETTER_W'($urandom_range(0, 31)));
               send_word(FUNC_ADD, rand_letter(), LETTER_W'($urandom_range(0, 31)));
            end else begin
               repeat ($urandom_range(0, 14))
                  send_word(FUNC_ADD, rand_letter(), LETTER_W'($urandom_range(0, 31)));
            end
            repeat ($urandom_range(1, 12)) begin
               a = rand_letter();
               b = ($urandom_range(0, 9) == 0) ? a : rand_letter();
               send_word($urandom_range(0, 1) ? FUNC_ENC : FUNC_DEC, a, b);
               // occasional key letter on a sealed square
               if ($urandom_range(0, 15) == 0)
                  send_word(FUNC_ADD, rand_letter(), LETTER_W'($urandom_range(0, 31)));
            end
         end
      end
      req_idle = 1'b1;
      rsp_idle = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      wipe_square();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_backpressure();
      test_random();

      // let any stray response word show up before the verdict
      wait_drained();
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // hang guard, far above the slowest legal run
   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* files.f */
design/pfdc_pkg.sv
design/pfdc_store.sv
design/playfair_digraph_cipher.sv
verif/tb.sv
